// ===== rtl/core/rrc_pkg.sv =====
// ============================================================================
// rrc_pkg: shared types and constants for the rotated rectangle corner block
// Fixed-point formats, the CORDIC arctangent table and the queue item type.
// ============================================================================
`default_nettype none

package rrc_pkg;

    // CORDIC iteration count and the size of the arctangent table
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CORNER_COUNT = 4;

    // Widths
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int IDX_W   = 2;
    localparam int XY_W    = 34;   // CORDIC x/y, Q2.30 plus guard bits
    localparam int Z_W     = 33;   // residual angle, 2^-32 turn units
    localparam int TRIG_W  = 32;   // clamped cos/sin, Q2.30
    localparam int PROD_W  = 64;

    // Configuration register map
    localparam int  PADDR_W      = 3;
    localparam logic REG_WIDTH   = 1'b0;
    localparam logic REG_HEIGHT  = 1'b1;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
    localparam logic signed [XY_W-1:0] Q30_ONE     = 34'sh0_4000_0000;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sh0000_0000_2000_0000;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Item handed from the front end to the back end
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [TRIG_W-1:0]  c;
        logic signed [TRIG_W-1:0]  s;
    } t_trig;

    // Arctangent of 2^-i in units of 2^-32 turn, rounded to nearest
    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rrc_if.sv =====
// ============================================================================
// rrc_in_if / rrc_out_if: item channels of the rotated rectangle corner block
// Valid/ready handshake with the item fields as payload.
// ============================================================================
`default_nettype none

interface rrc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rrc_pkg::COORD_W-1:0]    centre_x;
    logic signed [rrc_pkg::COORD_W-1:0]    centre_y;
    logic        [rrc_pkg::ANGLE_W-1:0]    turn_angle;

    modport source (output valid, centre_x, centre_y, turn_angle, input ready);
    modport sink   (input valid, centre_x, centre_y, turn_angle, output ready);
endinterface

interface rrc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic        [rrc_pkg::IDX_W-1:0]      corner_index;
    logic signed [rrc_pkg::COORD_W-1:0]    corner_x;
    logic signed [rrc_pkg::COORD_W-1:0]    corner_y;
    logic                                  last_corner;

    modport source (output valid, corner_index, corner_x, corner_y, last_corner,
                    input ready);
    modport sink   (input valid, corner_index, corner_x, corner_y, last_corner,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrc_front.sv =====
// ============================================================================
// rrc_front: item intake and pipelined CORDIC
// One CORDIC iteration per stage, then clamp and quadrant fold to cos/sin.
// ============================================================================
`default_nettype none

module rrc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rrc_in_if.sink             i_item,
    output rrc_pkg::t_trig     o_trig,
    output logic               o_push,
    input  wire logic          i_q_ready
);

    localparam int N = rrc_pkg::CORDIC_RUN;

    typedef struct packed {
        logic signed [rrc_pkg::XY_W-1:0]    x;
        logic signed [rrc_pkg::XY_W-1:0]    y;
        logic signed [rrc_pkg::Z_W-1:0]     z;
        logic        [1:0]                  q;
        logic signed [rrc_pkg::COORD_W-1:0] cx;
        logic signed [rrc_pkg::COORD_W-1:0] cy;
    } t_stage;

    t_stage     r_st [0:N];
    logic [N:0] r_v;
    logic       w_en;

    // Advance the whole pipe unless the last stage is blocked by the queue
    assign w_en         = !r_v[N] || i_q_ready;
    assign i_item.ready = w_en;
    assign o_push       = r_v[N];

    // Load stage zero with the starting vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_item.valid;
        end
        if (w_en) begin
            r_st[0].x  <= rrc_pkg::CORDIC_GAIN;
            r_st[0].y  <= '0;
            r_st[0].z  <= $signed({3'b000, i_item.turn_angle[13:0], 16'h0000});
            r_st[0].q  <= i_item.turn_angle[15:14];
            r_st[0].cx <= i_item.centre_x;
            r_st[0].cy <= i_item.centre_y;
        end
    end

    // One rotation step per stage
    for (genvar i = 0; i < N; i++) begin : g_iter
        logic signed [rrc_pkg::XY_W-1:0] w_xs;
        logic signed [rrc_pkg::XY_W-1:0] w_ys;
        logic signed [rrc_pkg::Z_W-1:0]  w_at;
        t_stage                          w_nx;

        assign w_xs = r_st[i].x >>> i;
        assign w_ys = r_st[i].y >>> i;
        assign w_at = $signed({1'b0, rrc_pkg::atan_turns(i)});

        always_comb begin
            w_nx = r_st[i];
            if (!r_st[i].z[rrc_pkg::Z_W-1]) begin
                w_nx.x = r_st[i].x - w_ys;
                w_nx.y = r_st[i].y + w_xs;
                w_nx.z = r_st[i].z - w_at;
            end else begin
                w_nx.x = r_st[i].x + w_ys;
                w_nx.y = r_st[i].y - w_xs;
                w_nx.z = r_st[i].z + w_at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (w_en) begin
                r_v[i+1] <= r_v[i];
            end
            if (w_en) begin
                r_st[i+1] <= w_nx;
            end
        end
    end

    // Clamp to [-1, 1] and fold the quadrant
    logic signed [rrc_pkg::XY_W-1:0]   w_xc;
    logic signed [rrc_pkg::XY_W-1:0]   w_yc;
    logic signed [rrc_pkg::TRIG_W-1:0] w_x;
    logic signed [rrc_pkg::TRIG_W-1:0] w_y;

    always_comb begin
        w_xc = r_st[N].x;
        if (w_xc > rrc_pkg::Q30_ONE)  w_xc = rrc_pkg::Q30_ONE;
        if (w_xc < -rrc_pkg::Q30_ONE) w_xc = -rrc_pkg::Q30_ONE;
        w_yc = r_st[N].y;
        if (w_yc > rrc_pkg::Q30_ONE)  w_yc = rrc_pkg::Q30_ONE;
        if (w_yc < -rrc_pkg::Q30_ONE) w_yc = -rrc_pkg::Q30_ONE;
        w_x = w_xc[rrc_pkg::TRIG_W-1:0];
        w_y = w_yc[rrc_pkg::TRIG_W-1:0];

        o_trig.cx = r_st[N].cx;
        o_trig.cy = r_st[N].cy;
        case (r_st[N].q)
            rrc_pkg::QUAD_0: begin o_trig.c = w_x;  o_trig.s = w_y;  end
            rrc_pkg::QUAD_1: begin o_trig.c = -w_y; o_trig.s = w_x;  end
            rrc_pkg::QUAD_2: begin o_trig.c = -w_x; o_trig.s = -w_y; end
            default:         begin o_trig.c = w_y;  o_trig.s = -w_x; end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrc_queue.sv =====
// ============================================================================
// rrc_queue: four-entry item queue between front and back end
// Register-based FIFO with an occupancy count.
// ============================================================================
`default_nettype none

module rrc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rrc_pkg::t_trig i_data,
    output logic                o_ready,
    output logic                o_valid,
    output rrc_pkg::t_trig      o_data,
    input  wire logic           i_pop
);

    rrc_pkg::t_trig r_mem [0:3];
    logic [1:0]     r_wp;
    logic [1:0]     r_rp;
    logic [2:0]     r_cnt;
    logic           w_wr;
    logic           w_rd;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    // Store on push
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Track pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 2'd1;
            if (w_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b00, w_wr} - {2'b00, w_rd};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rrc_back.sv =====
// ============================================================================
// rrc_back: corner generator
// Forms the four offset products per item, then emits one corner per cycle while the output is not stalled.
// ============================================================================
`default_nettype none

module rrc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire rrc_pkg::t_trig                i_trig,
    output logic                               o_pop,
    input  wire logic [rrc_pkg::COORD_W-1:0]   i_width,
    input  wire logic [rrc_pkg::COORD_W-1:0]   i_height,
    rrc_out_if.source                          o_corner
);

    localparam int W = rrc_pkg::PROD_W;

    logic                                  r_a_valid;
    logic signed [W-1:0]                   r_hwc, r_hhs, r_hws, r_hhc;
    logic signed [rrc_pkg::COORD_W-1:0]    r_cx, r_cy;
    logic        [rrc_pkg::IDX_W-1:0]      r_k;

    logic                                  r_o_valid;
    logic        [rrc_pkg::IDX_W-1:0]      r_o_idx;
    logic signed [rrc_pkg::COORD_W-1:0]    r_o_x, r_o_y;
    logic                                  r_o_last;

    logic signed [rrc_pkg::COORD_W-1:0]    w_hw, w_hh;
    logic                                  w_load, w_free, w_last;
    logic signed [rrc_pkg::COORD_W-1:0]    w_x, w_y;

    // Half sizes as non-negative signed operands
    assign w_hw = $signed({1'b0, i_width[rrc_pkg::COORD_W-1:1]});
    assign w_hh = $signed({1'b0, i_height[rrc_pkg::COORD_W-1:1]});

    assign w_last = (r_k == rrc_pkg::IDX_W'(rrc_pkg::CORNER_COUNT - 1));
    assign w_load = r_a_valid && (!r_o_valid || o_corner.ready);
    assign w_free = !r_a_valid || (w_load && w_last);
    assign o_pop  = w_free;

    // Round a sum of two products (46 fraction bits) to Q16.16, add centre, saturate
    function automatic logic signed [rrc_pkg::COORD_W-1:0] place(
        input logic signed [W-1:0]               a,
        input logic signed [W-1:0]               b,
        input logic signed [rrc_pkg::COORD_W-1:0] centre
    );
        logic signed [W-1:0] sum;
        logic signed [35:0]  v;
        sum = a + b + rrc_pkg::ROUND_HALF;
        v   = 36'(sum >>> 30) + 36'(centre);
        if (v > 36'sh0_7FFF_FFFF)       return 32'sh7FFF_FFFF;
        else if (v < -36'sh0_8000_0000) return 32'sh8000_0000;
        else                            return v[31:0];
    endfunction

    // Pick signs for the current corner
    always_comb begin
        logic sx_neg, sy_pos;
        sx_neg = !r_k[1];
        sy_pos = (r_k == 2'd0) || (r_k == 2'd3);
        w_x = place(sx_neg ? -r_hwc : r_hwc, sy_pos ? -r_hhs : r_hhs, r_cx);
        w_y = place(sx_neg ? -r_hws : r_hws, sy_pos ? r_hhc : -r_hhc, r_cy);
    end

    // Hold products of the current item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_k       <= '0;
        end else begin
            if (w_free) r_a_valid <= i_valid;
            if (w_load) r_k <= r_k + 2'd1;
        end
        if (w_free && i_valid) begin
            r_hwc <= W'(w_hw * i_trig.c);
            r_hhs <= W'(w_hh * i_trig.s);
            r_hws <= W'(w_hw * i_trig.s);
            r_hhc <= W'(w_hh * i_trig.c);
            r_cx  <= i_trig.cx;
            r_cy  <= i_trig.cy;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_corner.ready) begin
            r_o_valid <= 1'b0;
        end
        if (w_load) begin
            r_o_idx  <= r_k;
            r_o_x    <= w_x;
            r_o_y    <= w_y;
            r_o_last <= w_last;
        end
    end

    assign o_corner.valid        = r_o_valid;
    assign o_corner.corner_index = r_o_idx;
    assign o_corner.corner_x     = r_o_x;
    assign o_corner.corner_y     = r_o_y;
    assign o_corner.last_corner  = r_o_last;

endmodule

`default_nettype wire

// ===== rtl/core/rotated_rect_corners.sv =====
// Path: the first corner of an item passes through the CORDIC stage registers,
// the item queue, the back-end product registers and the output register.
// Flow: each item yields four corners over the one result channel; new items enter
// the CORDIC pipe meanwhile, and the pipe and queue absorb bursts.
// Reset: synchronous active-low; clears pipe, queue and output valids and
// sets both size registers to zero.
// ============================================================================
// rotated_rect_corners: top level of the rotated rectangle corner block
// APB size registers, CORDIC front end, item queue and corner back end.
// ============================================================================
`default_nettype none

module rotated_rect_corners (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rrc_in_if.sink                             i_item,
    rrc_out_if.source                          o_corner,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rrc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    logic [31:0]    r_width;
    logic [31:0]    r_height;
    rrc_pkg::t_trig w_f_trig, w_q_trig;
    logic           w_push, w_q_ready, w_q_valid, w_pop;

    // Register writes and reads
    assign pready = 1'b1;
    assign prdata = (paddr[2] == rrc_pkg::REG_HEIGHT) ? r_height : r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                rrc_pkg::REG_WIDTH:  r_width  <= pwdata;
                rrc_pkg::REG_HEIGHT: r_height <= pwdata;
                default: ;
            endcase
        end
    end

    rrc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_trig    (w_f_trig),
        .o_push    (w_push),
        .i_q_ready (w_q_ready)
    );

    rrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_trig),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_trig),
        .i_pop   (w_pop)
    );

    rrc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_trig   (w_q_trig),
        .o_pop    (w_pop),
        .i_width  (r_width),
        .i_height (r_height),
        .o_corner (o_corner)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rrc_checker.sv =====
// ============================================================================
// rrc_checker: port-level checks for the rotated rectangle corner block
// Corner ordering, last flag and output hold, bound to the top level.
// ============================================================================
`default_nettype none

module rrc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] out_idx,
    input wire logic [31:0] out_x,
    input wire logic [31:0] out_y,
    input wire logic       out_last
);

    // Hold a stalled corner
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(out_idx))
        else $error("stalled corner changed");

    // Flag the last corner exactly on index three
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_last == (out_idx == 2'd3)))
        else $error("last flag mismatch");

    // Follow a taken corner with the next one of the same item
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && out_idx != 2'd3 |=>
            out_valid && out_idx == $past(out_idx) + 2'd1)
        else $error("corner sequence broken");

    // Drop output valid after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("valid after reset");

endmodule

bind rotated_rect_corners rrc_checker u_rrc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_corner.valid),
    .out_ready (o_corner.ready),
    .out_idx   (o_corner.corner_index),
    .out_x     (o_corner.corner_x),
    .out_y     (o_corner.corner_y),
    .out_last  (o_corner.last_corner)
);

`default_nettype wire

// ===== sim/rotated_rect_corners_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// rotated_rect_corners_tb: self-checking bench for the rotated rectangle block
// Drives centre/angle items with random gaps, writes the size registers over
// APB between phases, predicts all four corners of each item in the bench and
// checks every corner against the oldest prediction.
// ============================================================================
`default_nettype none

module rotated_rect_corners_tb;

    localparam int  HALF_PERIOD = 4;
    localparam int  DRAIN_WAIT  = 40;
    localparam int  STALL_LIMIT = 4000;
    localparam logic [rrc_pkg::PADDR_W-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [rrc_pkg::PADDR_W-1:0] ADDR_HEIGHT = 3'd4;

    typedef struct {
        logic [rrc_pkg::IDX_W-1:0]          idx;
        logic signed [rrc_pkg::COORD_W-1:0] x;
        logic signed [rrc_pkg::COORD_W-1:0] y;
        logic                               last;
    } t_corner;

    // Arctangent of 2^-i, 2^-32 turn units
    localparam longint ATAN_LUT [24] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
        'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rrc_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rrc_in_if  in_ch ();
    rrc_out_if out_ch ();

    rotated_rect_corners u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (in_ch.sink),
        .o_corner (out_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    logic [31:0] size_w = '0;
    logic [31:0] size_h = '0;
    t_corner     corner_q [$];
    int          err_count = 0;
    int          items_sent = 0;
    int          corners_seen = 0;
    bit          no_idle = 1'b0;
    int          quiet_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.centre_x = '0;
        in_ch.centre_y = '0;
        in_ch.turn_angle = '0;
        out_ch.ready = 1'b0;
    end

    // Round a sum of products to Q16.16, add the centre and saturate
    function automatic logic signed [31:0] place_coord(input longint a, input longint b,
                                                       input longint centre);
        longint v;
        v = ((a + b + (longint'(1) << 29)) >>> 30) + centre;
        if (v < -(longint'(1) << 31)) v = -(longint'(1) << 31);
        if (v > (longint'(1) << 31) - 1) v = (longint'(1) << 31) - 1;
        return v[31:0];
    endfunction

    // Predict the four corners of one item and queue them
    task automatic predict_corners(input logic signed [31:0] cx, input logic signed [31:0] cy,
                                   input logic [15:0] ang);
        longint x, y, z, xs, ys, c, s, hw, hh, dx, dy;
        t_corner cr;
        x = longint'(rrc_pkg::CORDIC_GAIN);
        y = 0;
        z = longint'(ang[13:0]) << 16;
        for (int i = 0; i < rrc_pkg::CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_LUT[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_LUT[i];
            end
        end
        if (x > (longint'(1) << 30)) x = longint'(1) << 30;
        if (x < -(longint'(1) << 30)) x = -(longint'(1) << 30);
        if (y > (longint'(1) << 30)) y = longint'(1) << 30;
        if (y < -(longint'(1) << 30)) y = -(longint'(1) << 30);
        case (ang[15:14])
            rrc_pkg::QUAD_0: begin c = x;  s = y;  end
            rrc_pkg::QUAD_1: begin c = -y; s = x;  end
            rrc_pkg::QUAD_2: begin c = -x; s = -y; end
            default:         begin c = y;  s = -x; end
        endcase
        hw = longint'(size_w >> 1);
        hh = longint'(size_h >> 1);
        for (int k = 0; k < rrc_pkg::CORNER_COUNT; k++) begin
            dx = (k < 2) ? -hw : hw;
            dy = (k == 0 || k == 3) ? hh : -hh;
            cr.idx  = k[rrc_pkg::IDX_W-1:0];
            cr.x    = place_coord(dx * c, -(dy * s), longint'(cx));
            cr.y    = place_coord(dx * s, dy * c, longint'(cy));
            cr.last = (k == rrc_pkg::CORNER_COUNT - 1);
            corner_q = {corner_q, cr};
        end
    endtask

    // Send one item, with an optional random gap first
    task automatic send_item(input logic signed [31:0] cx, input logic signed [31:0] cy,
                             input logic [15:0] ang);
        int gap;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.centre_x = cx;
        in_ch.centre_y = cy;
        in_ch.turn_angle = ang;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_corners(cx, cy, ang);
        items_sent++;
    endtask

    // Drop valid and wait until every queued corner has come out
    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (corner_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Write one size register, then read it back
    task automatic apb_write(input logic [rrc_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_WIDTH) size_w = data;
        else size_h = data;
        @(negedge i_clk);
        pwrite = 1'b0; penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (prdata !== data) begin
            $error("register %0d readback: expected %h, actual %h", addr, data, prdata);
            err_count++;
        end
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    task automatic set_size(input logic [31:0] w, input logic [31:0] h);
        wait_idle();
        apb_write(ADDR_WIDTH, w);
        apb_write(ADDR_HEIGHT, h);
    endtask

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endfunction

    // Zero size: every corner is the centre, for all quadrants and extremes
    task automatic test_zero_size();
        send_item(32'sh0, 32'sh0, 16'h0000);
        send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 16'h4000);
        send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 16'h8000);
        send_item(32'sh0001_0000, -32'sh0001_0000, 16'hC000);
        send_item(32'shFFFF_FFFF, 32'sh5555_AAAA, 16'hFFFF);
    endtask

    // Unit-ish rectangle at angles on and near each quadrant boundary
    task automatic test_quadrants();
        logic [15:0] angles [10] = '{16'h0000, 16'h2000, 16'h3FFF, 16'h4000, 16'h6000,
                                     16'h8000, 16'hA000, 16'hC000, 16'hE000, 16'hFFFF};
        set_size(32'h0004_0000, 32'h0002_0000);
        foreach (angles[i]) send_item(32'sh0010_0000, -32'sh0008_0000, angles[i]);
    endtask

    // Huge size: offsets near full range, corners saturate
    task automatic test_huge_size();
        set_size(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'sh0, 32'sh0, 16'h0000);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'h1000);
        send_item(32'sh8000_0000, 32'sh8000_0000, 16'h9000);
        send_item(32'sh4000_0000, -32'sh4000_0000, 16'h5555);
        set_size(32'hFFFF_FFFF, 32'h0000_0000);
        send_item(32'sh0, 32'sh7FFF_FFFF, 16'h2AAA);
        send_item(32'sh8000_0000, 32'sh0, 16'hD555);
    endtask

    // Random items under a random size; optionally hold off once mid-way
    task automatic test_random(input int count, input bit hold_mid);
        set_size(rand_size(), rand_size());
        for (int n = 0; n < count; n++) begin
            if (hold_mid && n == count / 2) wait_idle();
            send_item(rand_coord(), rand_coord(), 16'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // Receiver stalls in random bursts
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 16);
                out_ch.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Compare each corner with the oldest prediction
    always @(posedge i_clk) begin
        t_corner e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            corners_seen++;
            if (corner_q.size() == 0) begin
                $error("corner with no prediction waiting: index %0d", out_ch.corner_index);
                err_count++;
            end else begin
                e = corner_q.pop_front();
                if (out_ch.corner_index !== e.idx) begin
                    $error("corner_index: expected %0d, actual %0d", e.idx,
                           out_ch.corner_index);
                    err_count++;
                end
                if (out_ch.corner_x !== e.x) begin
                    $error("corner_x: expected %h, actual %h", e.x, out_ch.corner_x);
                    err_count++;
                end
                if (out_ch.corner_y !== e.y) begin
                    $error("corner_y: expected %h, actual %h", e.y, out_ch.corner_y);
                    err_count++;
                end
                if (out_ch.last_corner !== e.last) begin
                    $error("last_corner: expected %0d, actual %0d", e.last,
                           out_ch.last_corner);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_zero_size();
        test_quadrants();
        test_huge_size();
        test_random(50, 1'b1);
        test_random(50, 1'b0);
        test_random(45, 1'b0);
        no_idle = 1'b1;
        test_random(45, 1'b0);
        wait_idle();
        if (corner_q.size() != 0) err_count++;
        $display("Sent %0d items, checked %0d corners over zero, small, huge and random sizes",
                 items_sent, corners_seen);
        $display("Covered all four quadrants, boundary angles and saturated corners");
        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/rrc_pkg.sv
rtl/core/rrc_if.sv
rtl/core/rrc_front.sv
rtl/core/rrc_queue.sv
rtl/core/rrc_back.sv
rtl/core/rotated_rect_corners.sv
rtl/core/rrc_checker.sv
sim/rotated_rect_corners_tb.sv
